// ----- rtl/llwd_pkg.sv -----
// Package for the least loaded work dispatcher: sizes, the link record that
// travels between neighboring cells, and saturating counter helpers.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package llwd_pkg;

	localparam int NUM_AGENTS = 8;
	localparam int AIDX_W     = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 88;

	localparam logic PH_SCAN = 1'b0;
	localparam logic PH_UPD  = 1'b1;

	typedef struct packed {
		logic              tok;
		logic              phase;
		logic [AIDX_W-1:0] pos;
		logic [15:0]       best;
		logic [AIDX_W-1:0] pick;
		logic              arrive;
		logic [7:0]        work;
		logic              idle;
		logic [15:0]       jc;
		logic [31:0]       lw;
	} link_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [7:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {25'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

	function automatic logic [2:0] agent_field(input logic [AIDX_W-1:0] idx);
		logic [2:0] f;
		f = 3'd0;
		for (int i = 0; i < 3; i++) begin
			if (i < AIDX_W) begin
				f[i] = idx[i];
			end
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/llwd_cell.sv -----
// One agent cell: holds the agent's counters, takes part in the minimum
// scan and the update pass, and registers the link toward its neighbor.
// Depends on llwd_pkg.
`default_nettype none

module llwd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  llwd_pkg::link_t link_in,
	output llwd_pkg::link_t link_out
);
	import llwd_pkg::*;

	logic [15:0] rem_q;
	logic [31:0] lw_q;
	logic [15:0] jc_q;
	link_t       link_q;

	logic        hit;
	logic        upd;
	logic [15:0] rem_add;
	logic [15:0] rem_new;
	logic [31:0] lw_new;
	logic [15:0] jc_new;
	link_t       nxt;

	always_comb begin
		upd     = link_in.tok && (link_in.phase == PH_UPD);
		hit     = link_in.arrive && (link_in.pick == link_in.pos);
		rem_add = hit ? sat_add16(rem_q, link_in.work) : rem_q;
		rem_new = (rem_add != 16'd0) ? rem_add - 16'd1 : 16'd0;
		lw_new  = hit ? sat_add32(lw_q, link_in.work) : lw_q;
		jc_new  = hit ? sat_inc16(jc_q) : jc_q;

		nxt     = link_in;
		nxt.pos = link_in.pos + AIDX_W'(1);
		if (link_in.phase == PH_SCAN) begin
			if ((link_in.pos == '0) || (rem_q < link_in.best)) begin
				nxt.best = rem_q;
				nxt.pick = link_in.pos;
			end
		end else begin
			nxt.idle = link_in.idle && (rem_new == 16'd0);
			if (hit) begin
				nxt.jc = jc_new;
				nxt.lw = lw_new;
			end
		end
		nxt.tok = link_in.tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			lw_q   <= '0;
			jc_q   <= '0;
			link_q <= '0;
		end else begin
			link_q <= nxt;
			if (upd) begin
				rem_q <= rem_new;
				lw_q  <= lw_new;
				jc_q  <= jc_new;
			end
		end
	end

	assign link_out = link_q;

endmodule

`default_nettype wire

// ----- rtl/llwd_ctrl.sv -----
// Sequencer for the dispatcher: takes requests, launches the scan and update
// tokens into the cell row, keeps the job total and the output register.
// Depends on llwd_pkg.
`default_nettype none

module llwd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [llwd_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [llwd_pkg::OUT_W-1:0] m_tdata,
	output llwd_pkg::link_t            head,
	input  llwd_pkg::link_t            tail
);
	import llwd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BUSY = 3'b010,
		ST_HOLD = 3'b100
	} ctrl_state_t;

	ctrl_state_t             state_q;
	link_t                   head_q;
	logic [31:0]             total_q;
	logic                    out_vld_q;
	logic [OUT_W-1:0]        out_q;
	logic [OUT_W-1:0]        hold_q;

	logic                    accept;
	logic                    scan_done;
	logic                    upd_done;
	logic                    out_free;
	logic [31:0]             total_new;
	logic [OUT_W-1:0]        result;

	always_comb begin
		accept    = s_tvalid && (state_q == ST_IDLE);
		scan_done = tail.tok && (tail.phase == PH_SCAN);
		upd_done  = tail.tok && (tail.phase == PH_UPD);
		out_free  = !out_vld_q || m_tready;
		total_new = tail.arrive ? sat_inc32(total_q) : total_q;
		result    = {3'd0, tail.idle, total_new,
			tail.arrive ? tail.lw : 32'd0,
			tail.arrive ? tail.jc : 16'd0,
			tail.arrive ? agent_field(tail.pick) : 3'd0,
			tail.arrive};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			hold_q    <= '0;
		end else begin
			head_q.tok <= 1'b0;
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q.tok    <= 1'b1;
						head_q.phase  <= PH_SCAN;
						head_q.pos    <= '0;
						head_q.best   <= 16'hFFFF;
						head_q.pick   <= '0;
						head_q.arrive <= s_tdata[0];
						head_q.work   <= s_tdata[8:1];
						head_q.idle   <= 1'b1;
						head_q.jc     <= '0;
						head_q.lw     <= '0;
						state_q       <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (scan_done) begin
						head_q       <= tail;
						head_q.tok   <= 1'b1;
						head_q.phase <= PH_UPD;
						head_q.pos   <= '0;
						head_q.idle  <= 1'b1;
						head_q.jc    <= '0;
						head_q.lw    <= '0;
					end else if (upd_done) begin
						total_q <= total_new;
						if (out_free) begin
							out_q     <= result;
							out_vld_q <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							hold_q  <= result;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_q     <= hold_q;
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign head     = head_q;

endmodule

`default_nettype wire

// ----- rtl/least_loaded_work_dispatcher_top.sv -----
// Top level of the least loaded work dispatcher: the sequencer and a row of
// NUM_AGENTS agent cells. Depends on llwd_pkg, llwd_cell and llwd_ctrl.
//
// Channel  Dir  Bits  Contents
// s_*      in   16    one tick request: arrive, work
// m_*      out  88    one result per request
//
// A request launches a scan token that walks the cell row one cell a cycle to
// find the least loaded agent, then an update token that walks it again,
// applies the dispatch and the work step and gathers the result. A new request
// is taken only after the result of the last one has reached the output
// register, so requests never overlap in the cell row.
// Reset clears all agent counters and the job total at once.
// A result that is not taken stays in the output register; a second finished
// result waits in a hold register, and new requests wait until it moves on.
`default_nettype none

module least_loaded_work_dispatcher_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// Fields from bit 0: arrive[0], work[8:1], zero fill.
	input  logic [llwd_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// Fields from bit 0: assigned[0], assigned_agent[3:1], agent_job_count[19:4],
	// agent_work_total[51:20], jobs_total[83:52], all_idle[84], zero fill.
	output logic [llwd_pkg::OUT_W-1:0] m_tdata
);
	import llwd_pkg::*;

	link_t links [NUM_AGENTS+1];

	llwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.head     (links[0]),
		.tail     (links[NUM_AGENTS])
	);

	for (genvar g = 0; g < NUM_AGENTS; g++) begin : g_cell
		llwd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (links[g]),
			.link_out (links[g+1])
		);
	end

endmodule

`default_nettype wire

// ----- sim/least_loaded_work_dispatcher_top_tb.sv -----
// Self-checking testbench for least_loaded_work_dispatcher_top: drives tick requests,
// predicts each result from a behavioral model of the agent row, and compares field by field.
// Depends on the RTL package llwd_pkg and the top level; reads nothing else.
`timescale 1ns / 1ps

module least_loaded_work_dispatcher_top_tb;

	import llwd_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic        assigned;
		logic [2:0]  agent;
		logic [15:0] job_count;
		logic [31:0] work_total;
		logic [31:0] jobs_total;
		logic        all_idle;
	} tick_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	logic [15:0] backlog [NUM_AGENTS];
	logic [31:0] work_given [NUM_AGENTS];
	logic [15:0] jobs_given [NUM_AGENTS];
	logic [31:0] dispatched;

	tick_result_t results_due [$];
	int          mismatches = 0;
	bit          gaps_on = 1'b1;
	int          ready_hold = 0;
	int          quiet_cycles = 0;

	least_loaded_work_dispatcher_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void predict_dispatch(input logic arrive, input logic [7:0] work);
		tick_result_t r;
		int           pick;
		logic [16:0]  sum16;
		logic [32:0]  sum32;
		bit           idle;
		r = '0;
		pick = 0;
		if (arrive) begin
			for (int i = 1; i < NUM_AGENTS; i++) begin
				if (backlog[i] < backlog[pick]) begin
					pick = i;
				end
			end
			sum16 = {1'b0, backlog[pick]} + {9'd0, work};
			backlog[pick] = sum16[16] ? 16'hFFFF : sum16[15:0];
			sum32 = {1'b0, work_given[pick]} + {25'd0, work};
			work_given[pick] = sum32[32] ? 32'hFFFF_FFFF : sum32[31:0];
			if (jobs_given[pick] != 16'hFFFF) begin
				jobs_given[pick]++;
			end
			if (dispatched != 32'hFFFF_FFFF) begin
				dispatched++;
			end
			r.assigned = 1'b1;
			r.agent = pick[2:0];
			r.job_count = jobs_given[pick];
			r.work_total = work_given[pick];
		end
		idle = 1'b1;
		for (int i = 0; i < NUM_AGENTS; i++) begin
			if (backlog[i] != 16'd0) begin
				backlog[i]--;
			end
			if (backlog[i] != 16'd0) begin
				idle = 1'b0;
			end
		end
		r.jobs_total = dispatched;
		r.all_idle = idle;
		results_due.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_tick(input logic arrive, input logic [7:0] work);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-9){1'b0}}, work, arrive};
		do @(posedge clk); while (!s_tready);
		predict_dispatch(arrive, work);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_work();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 8'd0;
		end else if (r < 60) begin
			return 8'($urandom_range(1, 20));
		end else if (r < 92) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'hFF;
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			tick_result_t want;
			if (results_due.size() == 0) begin
				report_mismatch("result with none expected", m_tdata[31:0], 32'd0);
			end else begin
				want = results_due.pop_front();
				if (m_tdata[0] !== want.assigned) begin
					report_mismatch("assigned", 32'(m_tdata[0]), 32'(want.assigned));
				end
				if (m_tdata[3:1] !== want.agent) begin
					report_mismatch("assigned_agent", 32'(m_tdata[3:1]), 32'(want.agent));
				end
				if (m_tdata[19:4] !== want.job_count) begin
					report_mismatch("agent_job_count", 32'(m_tdata[19:4]),
						32'(want.job_count));
				end
				if (m_tdata[51:20] !== want.work_total) begin
					report_mismatch("agent_work_total", m_tdata[51:20], want.work_total);
				end
				if (m_tdata[83:52] !== want.jobs_total) begin
					report_mismatch("jobs_total", m_tdata[83:52], want.jobs_total);
				end
				if (m_tdata[84] !== want.all_idle) begin
					report_mismatch("all_idle", 32'(m_tdata[84]), 32'(want.all_idle));
				end
			end
		end
	end

	// The result side alternates ready runs and stalls; the stalls are drawn like the request gaps.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!gaps_on) begin
			m_tready <= 1'b1;
		end else if (!m_tready) begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 12);
		end else begin
			m_tready <= 1'b0;
			ready_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL least_loaded_work_dispatcher_top");
			$finish;
		end
	end

	task automatic test_directed();
		send_tick(1'b0, 8'hFF);
		send_tick(1'b1, 8'h00);
		send_tick(1'b1, 8'h01);
		send_tick(1'b1, 8'h01);
		send_tick(1'b0, 8'h00);
		for (int i = 0; i < NUM_AGENTS + 1; i++) begin
			send_tick(1'b1, 8'hFF);
		end
		send_tick(1'b1, 8'h80);
		send_tick(1'b1, 8'h55);
		send_tick(1'b1, 8'hAA);
		send_tick(1'b0, 8'hAA);
		send_tick(1'b1, 8'h00);
		send_tick(1'b1, 8'h7F);
		send_tick(1'b0, 8'h55);
		drain_results();
	endtask

	task automatic test_random_mix(input int count);
		int arrive_pct;
		arrive_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: arrive_pct = 10;
					1: arrive_pct = 30;
					2: arrive_pct = 60;
					default: arrive_pct = 90;
				endcase
			end
			send_tick($urandom_range(0, 99) < arrive_pct, random_work());
		end
	endtask

	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		for (int n = 0; n < count; n++) begin
			send_tick(1'($urandom_range(0, 1)), random_work());
		end
		drain_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_pause_until_empty();
		test_random_mix(50);
		drain_results();
		test_random_mix(50);
	endtask

	task automatic test_sparse_arrivals(input int count);
		for (int n = 0; n < count; n++) begin
			send_tick($urandom_range(0, 99) < 8, 8'($urandom_range(0, 255)));
		end
	endtask

	// Long jobs arrive on every tick so that every agent carries a deep backlog.
	task automatic test_heavy_load(input int count);
		for (int n = 0; n < count; n++) begin
			send_tick(1'b1, 8'hFF);
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < NUM_AGENTS; i++) begin
			backlog[i] = '0;
			work_given[i] = '0;
			jobs_given[i] = '0;
		end
		dispatched = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(600);
		test_back_to_back(200);
		test_pause_until_empty();
		test_sparse_arrivals(300);
		test_heavy_load(30);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS least_loaded_work_dispatcher_top");
		end else begin
			$display("FAIL least_loaded_work_dispatcher_top");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/llwd_pkg.sv
rtl/llwd_cell.sv
rtl/llwd_ctrl.sv
rtl/least_loaded_work_dispatcher_top.sv
sim/least_loaded_work_dispatcher_top_tb.sv
